/* sv/bounded_ordered_list_top_macros.svh */
// Assertion helpers; the module that uses them supplies clk and rst.
`ifndef BOUNDED_ORDERED_LIST_TOP_MACROS_SVH
`define BOUNDED_ORDERED_LIST_TOP_MACROS_SVH

// Same-cycle implication.
`define BOL_CHECK_IMP(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication.
`define BOL_CHECK_NXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

/* sv/bol_pkg.sv */
`timescale 1ns / 1ps

package bol_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int VALUE_W      = 32;
  localparam int COUNT_W      = 5;

  typedef logic [1:0]                cmd_t;
  typedef logic [1:0]                status_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [COUNT_W-1:0]        count_t;

  localparam cmd_t CMD_INSERT       = 2'd0;
  localparam cmd_t CMD_REMOVE_FRONT = 2'd1;
  localparam cmd_t CMD_REMOVE_BACK  = 2'd2;
  localparam cmd_t CMD_DELETE_VALUE = 2'd3;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_EMPTY     = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;
  localparam status_t ST_FULL      = 2'd3;

endpackage

/* sv/bol_if.sv */
`timescale 1ns / 1ps

interface bol_req_if import bol_pkg::*; ();
  logic   valid;
  logic   ready;
  cmd_t   cmd;
  value_t item_value;

  modport source (output valid, output cmd, output item_value, input ready);
  modport sink   (input valid, input cmd, input item_value, output ready);
endinterface

interface bol_res_if import bol_pkg::*; ();
  logic    valid;
  logic    ready;
  count_t  entry_count;
  status_t status;

  modport source (output valid, output entry_count, output status, input ready);
  modport sink   (input valid, input entry_count, input status, output ready);
endinterface

/* sv/bounded_ordered_list_top.sv */
`timescale 1ns / 1ps
`include "bounded_ordered_list_top_macros.svh"

// Bounded ordered list of signed 32-bit values, up to CAPACITY entries.
// Channel req carries a request: cmd (insert at front, remove front,
// remove back, delete first matching value) and item_value. Channel res
// returns one result per request: entry_count after the request and a
// status (ok, empty, not found, full).
// The list sits in a circular buffer with a head pointer, held in one
// memory with a single write port and a registered read port.
// Insert and both removes go from acceptance through S_DONE to the
// output register. Delete-value scans from the front one entry per
// cycle through the read port, then moves each later entry up by one,
// one per cycle.
// req.ready is high only while no request is in work, so one request is
// worked on at a time: the next request can be taken as soon as the
// result is issued.
// A finished result waits in the output register
// while the next request is accepted; if res stalls, the following
// result holds in the sequencer until the register frees.
// Reset empties the list at once; no clearing pass is needed.
module bounded_ordered_list_top import bol_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic       clk,
  input logic       rst,
  bol_req_if.sink   req,
  bol_res_if.source res
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]    state;
  logic [CW-1:0] count;
  logic [AW-1:0] head;
  logic [AW-1:0] iss_ptr;
  logic [AW-1:0] chk_ptr;
  logic [AW-1:0] chk_idx;
  logic          chk_valid;
  logic [AW-1:0] left;
  value_t        value;
  status_t       res_st;
  logic          out_valid;
  count_t        out_count;
  status_t       out_status;

  value_t        mem [CAPACITY];
  value_t        rdata;

  logic          accept;
  logic          full;
  logic          match;
  logic          last_chk;
  logic          issue_live;
  logic          out_free;
  logic [CW-1:0] shift_n;
  logic [CW+COUNT_W-1:0] cnt_ext;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  value_t        mem_wdata;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(CAPACITY - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] p);
    return (p == '0) ? AW'(CAPACITY - 1) : p - 1'b1;
  endfunction

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign full      = (count == CW'(CAPACITY));
  assign match     = chk_valid && (rdata == value);
  assign last_chk  = (chk_idx == AW'(count - 1'b1));
  assign out_free  = !out_valid || res.ready;
  assign shift_n   = count - 1'b1 - CW'(chk_idx);
  assign cnt_ext   = {{COUNT_W{1'b0}}, count};

  assign res.valid       = out_valid;
  assign res.entry_count = out_count;
  assign res.status      = out_status;

  // Keep reads flowing until the scan or the move has seen its last entry.
  always_comb begin
    issue_live = 1'b0;
    if (state == S_SCAN) begin
      issue_live = !(chk_valid && (match || last_chk));
    end else if (state == S_SHIFT) begin
      issue_live = !(chk_valid && left == AW'(1));
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = chk_ptr;
    mem_wdata = rdata;
    if (accept && req.cmd == CMD_INSERT && !full) begin
      mem_we    = 1'b1;
      mem_waddr = wrap_dec(head);
      mem_wdata = req.item_value;
    end else if (state == S_SHIFT && chk_valid) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[iss_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      head      <= '0;
      chk_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      chk_valid <= issue_live;
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            value <= req.item_value;
            case (req.cmd)
              CMD_INSERT: begin
                state <= S_DONE;
                if (full) begin
                  res_st <= ST_FULL;
                end else begin
                  res_st <= ST_OK;
                  head   <= wrap_dec(head);
                  count  <= count + 1'b1;
                end
              end
              CMD_REMOVE_FRONT: begin
                state <= S_DONE;
                if (count == '0) begin
                  res_st <= ST_EMPTY;
                end else begin
                  res_st <= ST_OK;
                  head   <= wrap_inc(head);
                  count  <= count - 1'b1;
                end
              end
              CMD_REMOVE_BACK: begin
                state <= S_DONE;
                if (count == '0) begin
                  res_st <= ST_EMPTY;
                end else begin
                  res_st <= ST_OK;
                  count  <= count - 1'b1;
                end
              end
              default: begin
                if (count == '0) begin
                  res_st <= ST_NOT_FOUND;
                  state  <= S_DONE;
                end else begin
                  res_st  <= ST_OK;
                  state   <= S_SCAN;
                  iss_ptr <= head;
                  chk_ptr <= head;
                  chk_idx <= '0;
                end
              end
            endcase
          end
        end
        S_SCAN: begin
          if (chk_valid && match && shift_n != '0) begin
            iss_ptr <= wrap_inc(chk_ptr);
          end else begin
            iss_ptr <= wrap_inc(iss_ptr);
          end
          if (chk_valid) begin
            if (match) begin
              if (shift_n == '0) begin
                count <= count - 1'b1;
                state <= S_DONE;
              end else begin
                // chk_ptr stays as the write position for the move
                left  <= AW'(shift_n);
                state <= S_SHIFT;
              end
            end else if (last_chk) begin
              res_st <= ST_NOT_FOUND;
              state  <= S_DONE;
            end else begin
              chk_ptr <= wrap_inc(chk_ptr);
              chk_idx <= chk_idx + 1'b1;
            end
          end
        end
        S_SHIFT: begin
          iss_ptr <= wrap_inc(iss_ptr);
          if (chk_valid) begin
            chk_ptr <= wrap_inc(chk_ptr);
            left    <= left - 1'b1;
            if (left == AW'(1)) begin
              count <= count - 1'b1;
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_count  <= cnt_ext[COUNT_W-1:0];
            out_status <= res_st;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BOL_CHECK_IMP(a_count_bound, 1'b1, count <= CW'(CAPACITY), "entry count above capacity")
  `BOL_CHECK_NXT(a_insert_count, accept && req.cmd == CMD_INSERT && !full,
                 count == $past(count) + 1'b1, "insert did not grow the list")
  `BOL_CHECK_IMP(a_shift_left, state == S_SHIFT, left != '0, "move running with nothing left")
  `BOL_CHECK_NXT(a_done_issue, state == S_DONE && out_free,
                 out_valid && state == S_IDLE, "finished result not issued")

endmodule
